@@ rtl/ysc_pkg.sv @@
// ---------------------------------------------------------------------------
// ysc_pkg
// Shared types and constants for the YMODEM sender session controller.
// ---------------------------------------------------------------------------
package ysc_pkg;

    // Field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned BLOCK_W  = 18;
    localparam int unsigned OFFSET_W = 24;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned CFG_IDX_W = 2;

    // Block sizes in bytes
    localparam logic [COUNT_W-1:0] LONG_BLOCK_BYTES  = 11'd1024;
    localparam logic [COUNT_W-1:0] SHORT_BLOCK_BYTES = 11'd128;

    // Error limits
    localparam logic [2:0] DATA_ERR_MAX  = 3'd5;
    localparam logic [2:0] FINAL_ERR_MAX = 3'd3;

    // Receiver control characters
    localparam logic [BYTE_W-1:0] CH_C   = 8'h43;
    localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
    localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;
    localparam logic [BYTE_W-1:0] CH_CA  = 8'h18;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_LONG       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_NEEDED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_TMO_LIMIT = 2'd3;

    // Event codes on the request channel
    typedef enum logic [OP_W-1:0] {
        OP_START   = 2'd0,
        OP_BYTE    = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // Classified received byte
    typedef enum logic [2:0] {
        BC_C,
        BC_ACK,
        BC_NAK,
        BC_CA,
        BC_OTHER
    } t_bclass;

    // Commands to the packet path
    typedef enum logic [ACTION_W-1:0] {
        ACT_WAIT   = 3'd0,
        ACT_HEADER = 3'd1,
        ACT_DATA   = 3'd2,
        ACT_EOT    = 3'd3,
        ACT_FINAL  = 3'd4,
        ACT_DONE   = 3'd5,
        ACT_FAILED = 3'd6
    } t_action;

    // One classified event
    typedef struct packed {
        t_op     op;
        t_bclass bclass;
    } t_evt;

    // Head of the event queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_evt evt;
    } t_qhead;

    // Live configuration
    typedef struct packed {
        logic [OFFSET_W-1:0] file_length;
        logic                use_long;
        logic [7:0]          sync_needed;
        logic [7:0]          sync_tmo_limit;
    } t_cfg;

endpackage

@@ rtl/ysc_front.sv @@
// ---------------------------------------------------------------------------
// ysc_front
// Accepts event requests, classifies the received byte and holds the
// result in a two-entry queue for the session back end.
// ---------------------------------------------------------------------------
module ysc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ysc_pkg::OP_W-1:0]     i_op,
    input  logic [ysc_pkg::BYTE_W-1:0]   i_rx_byte,
    output ysc_pkg::t_qhead              o_head,
    input  logic                         i_pop
);

    ysc_pkg::t_evt  r_q [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count,  n_count;
    ysc_pkg::t_evt  w_evt;
    logic           w_push;
    logic           w_pop;

    // Byte classification
    always_comb begin
        w_evt.op = ysc_pkg::t_op'(i_op);
        case (i_rx_byte)
            ysc_pkg::CH_C:   w_evt.bclass = ysc_pkg::BC_C;
            ysc_pkg::CH_ACK: w_evt.bclass = ysc_pkg::BC_ACK;
            ysc_pkg::CH_NAK: w_evt.bclass = ysc_pkg::BC_NAK;
            ysc_pkg::CH_CA:  w_evt.bclass = ysc_pkg::BC_CA;
            default:         w_evt.bclass = ysc_pkg::BC_OTHER;
        endcase
    end

    assign o_in_ready = (r_count != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_pop && (r_count != 2'd0);

    // Queue pointers and fill level
    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_evt;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.evt   = r_q[r_rd_ptr];

endmodule

@@ rtl/ysc_back.sv @@
// ---------------------------------------------------------------------------
// ysc_back
// Session state machine: takes one classified event a cycle from the queue
// while the output register is free or draining, and loads its command there.
// ---------------------------------------------------------------------------
module ysc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ysc_pkg::t_cfg                 i_cfg,
    input  ysc_pkg::t_qhead               i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ysc_pkg::ACTION_W-1:0]  o_action,
    output logic [ysc_pkg::BLOCK_W-1:0]   o_block_number,
    output logic [ysc_pkg::OFFSET_W-1:0]  o_byte_offset,
    output logic [ysc_pkg::COUNT_W-1:0]   o_byte_count
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_SYNC, PH_HDR_ACK, PH_HDR_C, PH_DATA_ACK, PH_EOT_NAK,
        PH_EOT_ACK, PH_EOT_C, PH_FINAL_ACK, PH_DONE, PH_FAILED
    } t_phase;

    t_phase                          r_phase,      n_phase;
    logic [7:0]                      r_sync_seen,  n_sync_seen;
    logic [7:0]                      r_sync_tmo,   n_sync_tmo;
    logic [ysc_pkg::BLOCK_W-1:0]     r_block,      n_block;
    logic [ysc_pkg::OFFSET_W-1:0]    r_offset,     n_offset;
    logic [2:0]                      r_data_err,   n_data_err;
    logic [2:0]                      r_final_err,  n_final_err;
    logic                            r_out_valid,  n_out_valid;
    ysc_pkg::t_action                r_action,     n_action;
    logic [ysc_pkg::BLOCK_W-1:0]     r_out_block,  n_out_block;
    logic [ysc_pkg::OFFSET_W-1:0]    r_out_offset, n_out_offset;
    logic [ysc_pkg::COUNT_W-1:0]     r_out_count,  n_out_count;

    logic                            w_take;
    logic                            w_waiting;
    logic                            w_is_byte;
    logic [ysc_pkg::COUNT_W-1:0]     w_bs;
    logic [ysc_pkg::OFFSET_W:0]      w_rem;
    logic [ysc_pkg::OFFSET_W:0]      w_rem_next;
    logic                            w_last;
    logic [ysc_pkg::COUNT_W-1:0]     w_cnt_cur;
    logic [ysc_pkg::COUNT_W-1:0]     w_cnt_next;
    logic [ysc_pkg::COUNT_W-1:0]     w_cnt_first;
    logic [7:0]                      w_seen_inc;
    logic [7:0]                      w_tmo_inc;
    logic [2:0]                      w_data_err_inc;
    logic [2:0]                      w_final_err_inc;

    // Take an event when the output register is free or being drained
    assign w_take = i_head.valid && (!r_out_valid || i_out_ready);
    assign o_pop  = w_take;

    assign w_waiting = (r_phase != PH_IDLE) && (r_phase != PH_DONE)
                       && (r_phase != PH_FAILED);
    assign w_is_byte = (i_head.evt.op == ysc_pkg::OP_BYTE);

    // Block size and remaining-length arithmetic (signed remainder)
    assign w_bs = i_cfg.use_long ? ysc_pkg::LONG_BLOCK_BYTES
                                 : ysc_pkg::SHORT_BLOCK_BYTES;
    assign w_rem      = {1'b0, i_cfg.file_length} - {1'b0, r_offset};
    assign w_rem_next = w_rem - {{(ysc_pkg::OFFSET_W-ysc_pkg::COUNT_W+1){1'b0}}, w_bs};
    // Last block once the remainder fits in one block (or is negative)
    assign w_last = w_rem[ysc_pkg::OFFSET_W]
                    || (w_rem[ysc_pkg::OFFSET_W-1:0]
                        <= {{(ysc_pkg::OFFSET_W-ysc_pkg::COUNT_W){1'b0}}, w_bs});

    // Byte count for a resend of the current block
    always_comb begin
        if (w_rem[ysc_pkg::OFFSET_W] || (w_rem == '0)) begin
            w_cnt_cur = '0;
        end else if (w_rem[ysc_pkg::OFFSET_W-1:0]
                     > {{(ysc_pkg::OFFSET_W-ysc_pkg::COUNT_W){1'b0}}, w_bs}) begin
            w_cnt_cur = w_bs;
        end else begin
            w_cnt_cur = w_rem[ysc_pkg::COUNT_W-1:0];
        end
    end

    // Byte count for the following block (remainder known to be positive)
    always_comb begin
        if (w_rem_next[ysc_pkg::OFFSET_W-1:0]
            > {{(ysc_pkg::OFFSET_W-ysc_pkg::COUNT_W){1'b0}}, w_bs}) begin
            w_cnt_next = w_bs;
        end else begin
            w_cnt_next = w_rem_next[ysc_pkg::COUNT_W-1:0];
        end
    end

    // Byte count for block one
    always_comb begin
        if (i_cfg.file_length
            > {{(ysc_pkg::OFFSET_W-ysc_pkg::COUNT_W){1'b0}}, w_bs}) begin
            w_cnt_first = w_bs;
        end else begin
            w_cnt_first = i_cfg.file_length[ysc_pkg::COUNT_W-1:0];
        end
    end

    // Saturating sync counters and non-saturating error counters
    assign w_seen_inc = ((i_head.evt.bclass == ysc_pkg::BC_C) && (r_sync_seen != 8'hFF))
                        ? r_sync_seen + 8'd1 : r_sync_seen;
    assign w_tmo_inc  = (r_sync_tmo != 8'hFF) ? r_sync_tmo + 8'd1 : r_sync_tmo;
    assign w_data_err_inc  = r_data_err + 3'd1;
    assign w_final_err_inc = r_final_err + 3'd1;

    // Next-state logic
    always_comb begin
        n_phase      = r_phase;
        n_sync_seen  = r_sync_seen;
        n_sync_tmo   = r_sync_tmo;
        n_block      = r_block;
        n_offset     = r_offset;
        n_data_err   = r_data_err;
        n_final_err  = r_final_err;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_action     = r_action;
        n_out_block  = r_out_block;
        n_out_offset = r_out_offset;
        n_out_count  = r_out_count;

        if (w_take) begin
            n_out_valid  = 1'b1;
            n_action     = ysc_pkg::ACT_WAIT;
            n_out_block  = '0;
            n_out_offset = '0;
            n_out_count  = '0;

            if (i_head.evt.op == ysc_pkg::OP_START) begin
                // New session, abandons any running one
                n_sync_seen = '0;
                n_sync_tmo  = '0;
                n_block     = '0;
                n_offset    = '0;
                n_data_err  = '0;
                n_final_err = '0;
                n_phase     = PH_SYNC;
                if (i_cfg.sync_tmo_limit == 8'd0) begin
                    n_phase  = PH_FAILED;
                    n_action = ysc_pkg::ACT_FAILED;
                end
            end else if (i_head.evt.op == ysc_pkg::OP_NONE || !w_waiting) begin
                // ignored, answers wait
            end else if (w_is_byte && i_head.evt.bclass == ysc_pkg::BC_CA) begin
                n_phase  = PH_FAILED;
                n_action = ysc_pkg::ACT_FAILED;
            end else begin
                unique case (r_phase)
                    PH_SYNC: begin
                        if (w_is_byte) begin
                            n_sync_seen = w_seen_inc;
                            if (w_seen_inc >= i_cfg.sync_needed) begin
                                n_phase  = PH_HDR_ACK;
                                n_action = ysc_pkg::ACT_HEADER;
                            end
                        end else begin
                            n_sync_tmo = w_tmo_inc;
                            if (w_tmo_inc >= i_cfg.sync_tmo_limit) begin
                                n_phase  = PH_FAILED;
                                n_action = ysc_pkg::ACT_FAILED;
                            end
                        end
                    end
                    PH_HDR_ACK: begin
                        if (w_is_byte && i_head.evt.bclass == ysc_pkg::BC_ACK) begin
                            n_phase = PH_HDR_C;
                        end else begin
                            n_phase  = PH_FAILED;
                            n_action = ysc_pkg::ACT_FAILED;
                        end
                    end
                    PH_HDR_C: begin
                        if (w_is_byte && i_head.evt.bclass == ysc_pkg::BC_C) begin
                            n_block    = ysc_pkg::BLOCK_W'(1);
                            n_offset   = '0;
                            n_data_err = '0;
                            if (i_cfg.file_length == '0) begin
                                n_phase  = PH_EOT_NAK;
                                n_action = ysc_pkg::ACT_EOT;
                            end else begin
                                n_phase     = PH_DATA_ACK;
                                n_action    = ysc_pkg::ACT_DATA;
                                n_out_block = ysc_pkg::BLOCK_W'(1);
                                n_out_count = w_cnt_first;
                            end
                        end else begin
                            n_phase  = PH_FAILED;
                            n_action = ysc_pkg::ACT_FAILED;
                        end
                    end
                    PH_DATA_ACK: begin
                        if (w_is_byte && i_head.evt.bclass == ysc_pkg::BC_ACK) begin
                            if (w_last) begin
                                n_phase  = PH_EOT_NAK;
                                n_action = ysc_pkg::ACT_EOT;
                            end else begin
                                n_offset     = r_offset + {{(ysc_pkg::OFFSET_W-ysc_pkg::COUNT_W){1'b0}}, w_bs};
                                n_block      = r_block + ysc_pkg::BLOCK_W'(1);
                                n_action     = ysc_pkg::ACT_DATA;
                                n_out_block  = r_block + ysc_pkg::BLOCK_W'(1);
                                n_out_offset = r_offset + {{(ysc_pkg::OFFSET_W-ysc_pkg::COUNT_W){1'b0}}, w_bs};
                                n_out_count  = w_cnt_next;
                            end
                        end else begin
                            // NAK, stray byte or timeout: cumulative error count
                            n_data_err = w_data_err_inc;
                            if (w_data_err_inc > ysc_pkg::DATA_ERR_MAX) begin
                                n_phase  = PH_FAILED;
                                n_action = ysc_pkg::ACT_FAILED;
                            end else begin
                                n_action     = ysc_pkg::ACT_DATA;
                                n_out_block  = r_block;
                                n_out_offset = r_offset;
                                n_out_count  = w_cnt_cur;
                            end
                        end
                    end
                    PH_EOT_NAK: begin
                        if (w_is_byte && i_head.evt.bclass == ysc_pkg::BC_NAK) begin
                            n_phase  = PH_EOT_ACK;
                            n_action = ysc_pkg::ACT_EOT;
                        end else begin
                            n_phase  = PH_FAILED;
                            n_action = ysc_pkg::ACT_FAILED;
                        end
                    end
                    PH_EOT_ACK: begin
                        if (w_is_byte && i_head.evt.bclass == ysc_pkg::BC_ACK) begin
                            n_phase = PH_EOT_C;
                        end else begin
                            n_phase  = PH_FAILED;
                            n_action = ysc_pkg::ACT_FAILED;
                        end
                    end
                    PH_EOT_C: begin
                        if (w_is_byte && i_head.evt.bclass == ysc_pkg::BC_C) begin
                            n_final_err = '0;
                            n_phase     = PH_FINAL_ACK;
                            n_action    = ysc_pkg::ACT_FINAL;
                        end else begin
                            n_phase  = PH_FAILED;
                            n_action = ysc_pkg::ACT_FAILED;
                        end
                    end
                    PH_FINAL_ACK: begin
                        if (w_is_byte && i_head.evt.bclass == ysc_pkg::BC_ACK) begin
                            n_phase  = PH_DONE;
                            n_action = ysc_pkg::ACT_DONE;
                        end else begin
                            n_final_err = w_final_err_inc;
                            if (w_final_err_inc > ysc_pkg::FINAL_ERR_MAX) begin
                                n_phase  = PH_FAILED;
                                n_action = ysc_pkg::ACT_FAILED;
                            end else begin
                                n_action = ysc_pkg::ACT_FINAL;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_sync_seen <= '0;
            r_sync_tmo  <= '0;
            r_block     <= '0;
            r_offset    <= '0;
            r_data_err  <= '0;
            r_final_err <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_sync_seen <= n_sync_seen;
            r_sync_tmo  <= n_sync_tmo;
            r_block     <= n_block;
            r_offset    <= n_offset;
            r_data_err  <= n_data_err;
            r_final_err <= n_final_err;
            r_out_valid <= n_out_valid;
        end
        r_action     <= n_action;
        r_out_block  <= n_out_block;
        r_out_offset <= n_out_offset;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid    = r_out_valid;
    assign o_action       = r_action;
    assign o_block_number = r_out_block;
    assign o_byte_offset  = r_out_offset;
    assign o_byte_count   = r_out_count;

endmodule

@@ rtl/ymodem_sender_controller_unit.sv @@
// ---------------------------------------------------------------------------
// ymodem_sender_controller_unit
// YMODEM sender session controller: one command per session event.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one event per request:
//   start, received byte (i_rx_byte) or receive timeout. Output channel
//   (o_out_valid / i_out_ready) returns exactly one command per event:
//   wait, header, data block (number, offset, byte count), EOT, final,
//   done or failed.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while no event is outstanding; registers are used live.
//   An accepted event is registered in the front queue; its command is then
//   registered in the output register of the session state machine.
//   Throughput: one event per cycle while the receiver does not stall
//   the output channel.
//   Reset (i_rst_n low, synchronous) empties the queue, drops any pending
//   command, puts the session in idle and loads the register defaults.
//   When the receiver stalls, the command is held in the output register
//   and up to two further events wait in the front queue before
//   o_in_ready drops.
// ---------------------------------------------------------------------------
module ymodem_sender_controller_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ysc_pkg::OP_W-1:0]         i_op,
    input  logic [ysc_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ysc_pkg::ACTION_W-1:0]     o_action,
    output logic [ysc_pkg::BLOCK_W-1:0]      o_block_number,
    output logic [ysc_pkg::OFFSET_W-1:0]     o_byte_offset,
    output logic [ysc_pkg::COUNT_W-1:0]      o_byte_count,
    input  logic                             i_cfg_we,
    input  logic [ysc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ysc_pkg::CFG_W-1:0]        i_cfg_data
);

    ysc_pkg::t_cfg    r_cfg;
    ysc_pkg::t_qhead  w_head;
    logic             w_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.file_length    <= '0;
            r_cfg.use_long       <= 1'b0;
            r_cfg.sync_needed    <= 8'd1;
            r_cfg.sync_tmo_limit <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ysc_pkg::REG_FILE_LENGTH:    r_cfg.file_length    <= i_cfg_data;
                ysc_pkg::REG_USE_LONG:       r_cfg.use_long       <= i_cfg_data[0];
                ysc_pkg::REG_SYNC_NEEDED:    r_cfg.sync_needed    <= i_cfg_data[7:0];
                ysc_pkg::REG_SYNC_TMO_LIMIT: r_cfg.sync_tmo_limit <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Front: accept, classify, queue
    ysc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_rx_byte  (i_rx_byte),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // Back: session state machine and output register
    ysc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action       (o_action),
        .o_block_number (o_block_number),
        .o_byte_offset  (o_byte_offset),
        .o_byte_count   (o_byte_count)
    );

    // Only data commands carry block fields
    a_fields_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action != ysc_pkg::ACT_DATA)) |->
        ((o_block_number == '0) && (o_byte_offset == '0) && (o_byte_count == '0)))
        else $error("non-data command carries block fields");

    // Data commands never exceed a long block and are never block zero
    a_data_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action == ysc_pkg::ACT_DATA)) |->
        ((o_byte_count <= ysc_pkg::LONG_BLOCK_BYTES) && (o_block_number != '0)))
        else $error("data command out of range");

    // Queue is only popped with an event present
    a_pop_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("event taken from empty queue");

    // Reset drops any pending command
    a_reset_clear : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("command pending after reset");

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YMODEM sender session controller. A scoreboard
// class tracks the session phase, counters and live registers, predicts the
// command for every accepted event and checks each command the block returns.
// Stimulus steers mostly well-formed sessions with random noise, under
// random register settings and random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 20;
    localparam int RANDOM_REQUESTS = 750;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 10;

    // Session phases tracked by the scoreboard
    typedef enum logic [3:0] {
        S_IDLE, S_SYNC, S_HDR_ACK, S_HDR_C, S_DATA_ACK, S_EOT_NAK,
        S_EOT_ACK, S_EOT_C, S_FINAL_ACK, S_DONE, S_FAILED
    } t_session;

    // One command as returned on the output channel
    typedef struct packed {
        ysc_pkg::t_action             action;
        logic [ysc_pkg::BLOCK_W-1:0]  blk;
        logic [ysc_pkg::OFFSET_W-1:0] off;
        logic [ysc_pkg::COUNT_W-1:0]  cnt;
    } t_command;

    // -----------------------------------------------------------------------
    // Scoreboard: session predictor plus the queue of commands still due
    // -----------------------------------------------------------------------
    class session_scoreboard;
        t_session                     phase;
        logic [ysc_pkg::OFFSET_W-1:0] file_len;
        logic                         long_blocks;
        logic [7:0]                   sync_need;
        logic [7:0]                   tmo_limit;
        logic [7:0]                   c_seen;
        logic [7:0]                   tmo_seen;
        logic [ysc_pkg::BLOCK_W-1:0]  blk;
        logic [ysc_pkg::OFFSET_W-1:0] offset;
        logic [2:0]                   data_errs;
        logic [2:0]                   final_errs;
        t_command                     due_commands[$];
        int                           errors;
        int                           checked;
        int                           sessions_done;
        int                           sessions_failed;

        function new();
            phase       = S_IDLE;
            file_len    = '0;
            long_blocks = 1'b0;
            sync_need   = 8'd1;
            tmo_limit   = 8'd10;
            c_seen      = '0;
            tmo_seen    = '0;
            blk         = '0;
            offset      = '0;
            data_errs   = '0;
            final_errs  = '0;
            errors      = 0;
            checked     = 0;
            sessions_done   = 0;
            sessions_failed = 0;
        endfunction

        function void write_reg(input logic [ysc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ysc_pkg::CFG_W-1:0] val);
            case (idx)
                ysc_pkg::REG_FILE_LENGTH:    file_len    = val[ysc_pkg::OFFSET_W-1:0];
                ysc_pkg::REG_USE_LONG:       long_blocks = val[0];
                ysc_pkg::REG_SYNC_NEEDED:    sync_need   = val[7:0];
                ysc_pkg::REG_SYNC_TMO_LIMIT: tmo_limit   = val[7:0];
                default: ;
            endcase
        endfunction

        function logic [ysc_pkg::COUNT_W-1:0] block_bytes();
            return long_blocks ? ysc_pkg::LONG_BLOCK_BYTES : ysc_pkg::SHORT_BLOCK_BYTES;
        endfunction

        function t_command cmd(input ysc_pkg::t_action a,
                               input logic [ysc_pkg::BLOCK_W-1:0] b,
                               input logic [ysc_pkg::OFFSET_W-1:0] o,
                               input logic [ysc_pkg::COUNT_W-1:0] n);
            t_command c;
            c.action = a;
            c.blk    = b;
            c.off    = o;
            c.cnt    = n;
            return c;
        endfunction

        function t_command abort_session();
            phase = S_FAILED;
            return cmd(ysc_pkg::ACT_FAILED, '0, '0, '0);
        endfunction

        // Data block at the current offset; count clipped to what is left
        function t_command data_block();
            logic [ysc_pkg::OFFSET_W-1:0] left;
            logic [ysc_pkg::COUNT_W-1:0]  n;
            n = '0;
            if (offset < file_len) begin
                left = file_len - offset;
                n = (left < block_bytes()) ? left[ysc_pkg::COUNT_W-1:0] : block_bytes();
            end
            phase = S_DATA_ACK;
            return cmd(ysc_pkg::ACT_DATA, blk, offset, n);
        endfunction

        function t_command first_eot();
            phase = S_EOT_NAK;
            return cmd(ysc_pkg::ACT_EOT, '0, '0, '0);
        endfunction

        function bit in_session();
            return !(phase inside {S_IDLE, S_DONE, S_FAILED});
        endfunction

        // Predict the command for one accepted request
        function void note_request(input logic [ysc_pkg::OP_W-1:0] op,
                                   input logic [ysc_pkg::BYTE_W-1:0] rxb);
            logic [ysc_pkg::OFFSET_W:0] next_off;
            t_command                   c;
            bit                         is_byte;
            c = cmd(ysc_pkg::ACT_WAIT, '0, '0, '0);
            is_byte = (op == ysc_pkg::OP_BYTE);
            if (op == ysc_pkg::OP_START) begin
                c_seen     = '0;
                tmo_seen   = '0;
                blk        = '0;
                offset     = '0;
                data_errs  = '0;
                final_errs = '0;
                phase      = S_SYNC;
                if (tmo_limit == 8'd0)
                    c = abort_session();
            end else if (op == ysc_pkg::OP_NONE || !in_session()) begin
                // ignored
            end else if (is_byte && rxb == ysc_pkg::CH_CA) begin
                c = abort_session();
            end else begin
                case (phase)
                    S_SYNC: begin
                        if (is_byte) begin
                            if (rxb == ysc_pkg::CH_C && c_seen != 8'hFF)
                                c_seen = c_seen + 8'd1;
                            if (c_seen >= sync_need) begin
                                phase = S_HDR_ACK;
                                c = cmd(ysc_pkg::ACT_HEADER, '0, '0, '0);
                            end
                        end else begin
                            if (tmo_seen != 8'hFF)
                                tmo_seen = tmo_seen + 8'd1;
                            if (tmo_seen >= tmo_limit)
                                c = abort_session();
                        end
                    end
                    S_HDR_ACK: begin
                        if (is_byte && rxb == ysc_pkg::CH_ACK) phase = S_HDR_C;
                        else c = abort_session();
                    end
                    S_HDR_C: begin
                        if (is_byte && rxb == ysc_pkg::CH_C) begin
                            blk       = ysc_pkg::BLOCK_W'(1);
                            offset    = '0;
                            data_errs = '0;
                            if (file_len == '0) c = first_eot();
                            else c = data_block();
                        end else begin
                            c = abort_session();
                        end
                    end
                    S_DATA_ACK: begin
                        if (is_byte && rxb == ysc_pkg::CH_ACK) begin
                            next_off = {1'b0, offset} + block_bytes();
                            if (next_off >= {1'b0, file_len}) begin
                                c = first_eot();
                            end else begin
                                offset = next_off[ysc_pkg::OFFSET_W-1:0];
                                blk    = blk + 1'b1;
                                c      = data_block();
                            end
                        end else begin
                            // errors add up over the whole data phase
                            data_errs = data_errs + 3'd1;
                            if (data_errs > ysc_pkg::DATA_ERR_MAX) c = abort_session();
                            else c = data_block();
                        end
                    end
                    S_EOT_NAK: begin
                        if (is_byte && rxb == ysc_pkg::CH_NAK) begin
                            phase = S_EOT_ACK;
                            c = cmd(ysc_pkg::ACT_EOT, '0, '0, '0);
                        end else begin
                            c = abort_session();
                        end
                    end
                    S_EOT_ACK: begin
                        if (is_byte && rxb == ysc_pkg::CH_ACK) phase = S_EOT_C;
                        else c = abort_session();
                    end
                    S_EOT_C: begin
                        if (is_byte && rxb == ysc_pkg::CH_C) begin
                            final_errs = '0;
                            phase = S_FINAL_ACK;
                            c = cmd(ysc_pkg::ACT_FINAL, '0, '0, '0);
                        end else begin
                            c = abort_session();
                        end
                    end
                    S_FINAL_ACK: begin
                        if (is_byte && rxb == ysc_pkg::CH_ACK) begin
                            phase = S_DONE;
                            c = cmd(ysc_pkg::ACT_DONE, '0, '0, '0);
                        end else begin
                            final_errs = final_errs + 3'd1;
                            if (final_errs > ysc_pkg::FINAL_ERR_MAX) c = abort_session();
                            else c = cmd(ysc_pkg::ACT_FINAL, '0, '0, '0);
                        end
                    end
                    default: ;
                endcase
            end
            due_commands.push_back(c);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one returned command with the oldest one due
        function void check_command(input logic [ysc_pkg::ACTION_W-1:0] act,
                                    input logic [ysc_pkg::BLOCK_W-1:0] b,
                                    input logic [ysc_pkg::OFFSET_W-1:0] o,
                                    input logic [ysc_pkg::COUNT_W-1:0] n);
            t_command want;
            if (due_commands.size() == 0) begin
                $error("command with none due: action %0d", act);
                errors++;
                return;
            end
            want = due_commands.pop_front();
            checked++;
            compare_field("action", 32'(want.action), 32'(act));
            compare_field("block_number", 32'(want.blk), 32'(b));
            compare_field("byte_offset", 32'(want.off), 32'(o));
            compare_field("byte_count", 32'(want.cnt), 32'(n));
            if (want.action == ysc_pkg::ACT_DONE) sessions_done++;
            if (want.action == ysc_pkg::ACT_FAILED) sessions_failed++;
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals and block under test
    // -----------------------------------------------------------------------
    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [ysc_pkg::OP_W-1:0]      i_op;
    logic [ysc_pkg::BYTE_W-1:0]    i_rx_byte;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [ysc_pkg::ACTION_W-1:0]  o_action;
    logic [ysc_pkg::BLOCK_W-1:0]   o_block_number;
    logic [ysc_pkg::OFFSET_W-1:0]  o_byte_offset;
    logic [ysc_pkg::COUNT_W-1:0]   o_byte_count;
    logic                          i_cfg_we;
    logic [ysc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [ysc_pkg::CFG_W-1:0]     i_cfg_data;

    session_scoreboard sb = new();
    bit                send_steady;
    int                n_settings;

    ymodem_sender_controller_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action       (o_action),
        .o_block_number (o_block_number),
        .o_byte_offset  (o_byte_offset),
        .o_byte_count   (o_byte_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Driver tasks; all are entered and left just after a falling edge
    // -----------------------------------------------------------------------
    task automatic send_request(input logic [ysc_pkg::OP_W-1:0] op,
                                input logic [ysc_pkg::BYTE_W-1:0] rxb);
        int gap;
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op       = op;
        i_rx_byte  = rxb;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, rxb);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ysc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ysc_pkg::CFG_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    // Registers change only with no command outstanding
    task automatic apply_settings(input logic [ysc_pkg::OFFSET_W-1:0] len, input logic lng,
                                  input logic [7:0] sn, input logic [7:0] tmo,
                                  input logic [3:0] mask);
        i_in_valid = 1'b0;
        while (sb.due_commands.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        if (mask[0]) write_reg(ysc_pkg::REG_FILE_LENGTH, ysc_pkg::CFG_W'(len));
        if (mask[1]) write_reg(ysc_pkg::REG_USE_LONG, ysc_pkg::CFG_W'(lng));
        if (mask[2]) write_reg(ysc_pkg::REG_SYNC_NEEDED, ysc_pkg::CFG_W'(sn));
        if (mask[3]) write_reg(ysc_pkg::REG_SYNC_TMO_LIMIT, ysc_pkg::CFG_W'(tmo));
        i_cfg_we = 1'b0;
        n_settings++;
    endtask

    // Mostly the byte the session waits for, now and then noise
    task automatic pick_request(output logic [ysc_pkg::OP_W-1:0] op,
                                output logic [ysc_pkg::BYTE_W-1:0] rxb);
        int r;
        r   = $urandom_range(0, 99);
        rxb = ysc_pkg::BYTE_W'($urandom);
        op  = ysc_pkg::OP_BYTE;
        if (!sb.in_session()) begin
            if (r < 80) op = ysc_pkg::OP_START;
            else op = ysc_pkg::OP_W'($urandom);
        end else if (r < 88) begin
            case (sb.phase) inside
                S_HDR_ACK, S_DATA_ACK, S_EOT_ACK, S_FINAL_ACK: rxb = ysc_pkg::CH_ACK;
                S_EOT_NAK: rxb = ysc_pkg::CH_NAK;
                default:   rxb = ysc_pkg::CH_C;
            endcase
        end else begin
            case (r % 6)
                0: op  = ysc_pkg::OP_TIMEOUT;
                2: rxb = ysc_pkg::CH_CA;
                3: op  = ysc_pkg::OP_START;
                4: op  = ysc_pkg::OP_NONE;
                5: rxb = ysc_pkg::CH_NAK;
                default: ;   // random byte
            endcase
        end
    endtask

    // -----------------------------------------------------------------------
    // Receiver: random stall before each command, then check it
    // -----------------------------------------------------------------------
    initial begin : receiver
        int stall;
        bit steady;
        i_out_ready = 1'b0;
        steady = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_command(o_action, o_block_number, o_byte_offset, o_byte_count);
            @(negedge i_clk);
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: too long without any request moving on either channel
    // -----------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin : stimulus
        logic [ysc_pkg::OP_W-1:0]     op;
        logic [ysc_pkg::BYTE_W-1:0]   rxb;
        logic [ysc_pkg::OFFSET_W-1:0] len;
        logic                         lng;
        logic [7:0]                   sn;
        logic [7:0]                   tmo;
        int                           counted;
        int                           left_in_setting;
        int                           r;
        int                           bsz;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = ysc_pkg::OP_NONE;
        i_rx_byte   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        send_steady = 1'b0;
        n_settings  = 0;
        counted     = 0;
        left_in_setting = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: idle ignores everything but start; empty file; abort
        send_request(ysc_pkg::OP_NONE, 8'h00);
        send_request(ysc_pkg::OP_BYTE, 8'hFF);
        send_request(ysc_pkg::OP_TIMEOUT, 8'h00);
        send_request(ysc_pkg::OP_START, 8'h00);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_C);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_ACK);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_C);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_NAK);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_CA);

        // Full session: sync on any byte, a resent block, a resent final block
        apply_settings(24'd200, 1'b0, 8'd0, 8'd255, 4'b1111);
        send_request(ysc_pkg::OP_START, 8'h00);
        send_request(ysc_pkg::OP_BYTE, 8'h00);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_ACK);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_C);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_NAK);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_ACK);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_ACK);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_NAK);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_ACK);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_C);
        send_request(ysc_pkg::OP_TIMEOUT, 8'h00);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_ACK);
        send_request(ysc_pkg::OP_BYTE, ysc_pkg::CH_C);

        // Zero timeout limit fails at start
        apply_settings(24'hFFFFFF, 1'b1, 8'd255, 8'd0, 4'b1111);
        send_request(ysc_pkg::OP_START, 8'h00);

        // Random sessions under changing settings
        while (counted < RANDOM_REQUESTS) begin
            if (left_in_setting == 0) begin
                lng = 1'($urandom_range(0, 1));
                bsz = lng ? 1024 : 128;
                r = $urandom_range(0, 99);
                if (r < 10)      len = '0;
                else if (r < 20) len = '1;
                else if (r < 35) len = ysc_pkg::OFFSET_W'(bsz * $urandom_range(1, 4));
                else if (r < 40) len = 24'd1;
                else             len = ysc_pkg::OFFSET_W'($urandom_range(1, 4 * bsz + 100));
                r = $urandom_range(0, 99);
                if (r < 45)      sn = 8'd1;
                else if (r < 65) sn = 8'd0;
                else if (r < 95) sn = 8'($urandom_range(2, 4));
                else             sn = 8'd255;
                r = $urandom_range(0, 99);
                if (r < 5)       tmo = 8'd0;
                else if (r < 15) tmo = 8'd255;
                else             tmo = 8'($urandom_range(1, 12));
                apply_settings(len, lng, sn, tmo, 4'($urandom_range(1, 15)));
                left_in_setting = $urandom_range(10, 40);
            end
            pick_request(op, rxb);
            counted++;
            send_request(op, rxb);
            left_in_setting--;
        end

        // Drain
        i_in_valid = 1'b0;
        while (sb.due_commands.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d commands over %0d register settings", sb.checked, n_settings);
        $display("sessions completed: %0d, sessions failed: %0d, mismatches: %0d",
                 sb.sessions_done, sb.sessions_failed, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ysc_pkg.sv
rtl/ysc_front.sv
rtl/ysc_back.sv
rtl/ymodem_sender_controller_unit.sv
tb/tb_top.sv
